### sv/lanc_pkg.sv
// shared types and constants for the lanc datagram controller
package lanc_pkg;

  // event kinds carried in the action field
  typedef enum logic [1:0] {
    ACT_RX_BYTE = 2'd0,
    ACT_START   = 2'd1,
    ACT_TICK    = 2'd2,
    ACT_STAGE   = 2'd3
  } action_t;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAP_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_INVERT = 2'd1;

  // register reset values
  localparam logic [7:0] GAP_THRESHOLD_RESET = 8'd5;
  localparam logic       OUTPUT_INVERT_RESET = 1'b1;

  // frame bytes that are visible on the status outputs
  localparam int unsigned STATUS_FIRST = 2;
  localparam int unsigned STATUS_LAST  = 7;
  localparam int unsigned STORE_DEPTH  = 8;

endpackage

### sv/lanc_datagram_controller.sv
// lanc datagram controller: frame receive, command staging and bit-serial send
//
// Every accepted word is one event: received byte, start bit, bit tick or command
// stage. A word is taken every cycle unless in_stall is high; it is held in the input
// register, its state update is done by the logic behind that register, and the result
// word lands in the output register. Throughput is one word per cycle when no stall
// holds the flow. A stall on the result side holds the output register; the input
// register still takes one more word while the result waits, and in_stall rises only
// when both are full. Configuration writes are always ready and take effect at once.
module lanc_datagram_controller
  import lanc_pkg::*;
#(
  parameter int unsigned FRAME_LENGTH = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // event input
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             action,
  input  logic [7:0]             rx_byte,
  input  logic [31:0]            now_ms,
  input  logic [7:0]             cmd_first,
  input  logic [7:0]             cmd_second,
  // result output
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   line_level,
  output logic                   tx_busy,
  output logic                   start_armed,
  output logic                   frame_done,
  output logic [7:0]             status_b2,
  output logic [7:0]             status_b3,
  output logic [7:0]             status_b4,
  output logic [7:0]             status_b5,
  output logic [7:0]             status_b6,
  output logic [7:0]             status_b7,
  // configuration write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data
);

  localparam logic [7:0] POS_LAST = 8'(FRAME_LENGTH - 1);

  // configuration registers
  logic [7:0] gap_threshold;
  logic       output_inverted;

  // input register
  logic       s1_valid;
  action_t    s1_action;
  logic [7:0] s1_rx_byte;
  logic [31:0] s1_now_ms;
  logic [7:0] s1_cmd_first;
  logic [7:0] s1_cmd_second;

  // controller state
  logic [7:0]  frame_position, frame_position_next;
  logic [31:0] last_byte_time, last_byte_time_next;
  logic [7:0]  frame_store [STORE_DEPTH];
  logic [7:0]  frame_store_next [STORE_DEPTH];
  logic [7:0]  staged_command [2];
  logic [7:0]  staged_command_next [2];
  logic [7:0]  published_frame [STATUS_FIRST:STATUS_LAST];
  logic [7:0]  published_frame_next [STATUS_FIRST:STATUS_LAST];
  logic        trigger_armed, trigger_armed_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [3:0]  bit_index, bit_index_next;
  logic        sending, sending_next;
  logic        line_state, line_state_next;
  logic        done_next;

  logic        advance;
  logic        process;
  logic        cfg_write;
  logic [7:0]  rx_data;
  logic [31:0] gap;
  logic        tx_bit;

  // handshake control
  assign advance   = !out_valid || !out_stall;
  assign process   = s1_valid && advance;
  assign in_stall  = s1_valid && !advance;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_action     <= action_t'(action);
      s1_rx_byte    <= rx_byte;
      s1_now_ms     <= now_ms;
      s1_cmd_first  <= cmd_first;
      s1_cmd_second <= cmd_second;
    end
  end

  assign rx_data = ~s1_rx_byte;
  assign gap     = s1_now_ms - last_byte_time;
  assign tx_bit  = shift_byte[bit_index[2:0]];

  // event handling
  always_comb begin
    frame_position_next  = frame_position;
    last_byte_time_next  = last_byte_time;
    frame_store_next     = frame_store;
    staged_command_next  = staged_command;
    published_frame_next = published_frame;
    trigger_armed_next   = trigger_armed;
    shift_byte_next      = shift_byte;
    bit_index_next       = bit_index;
    sending_next         = sending;
    line_state_next      = line_state;
    done_next            = 1'b0;

    unique case (s1_action)
      ACT_RX_BYTE: begin
        if (gap > {24'd0, gap_threshold}) begin
          frame_position_next = 8'd0;
        end else begin
          frame_position_next = frame_position + 8'd1;
        end
        if (frame_position_next == 8'd0 || frame_position_next == POS_LAST) begin
          trigger_armed_next = 1'b1;
        end
        last_byte_time_next = s1_now_ms;
        for (int k = STATUS_FIRST; k < STORE_DEPTH; k++) begin
          if (frame_position_next == 8'(k) && k <= FRAME_LENGTH - 1) begin
            frame_store_next[k] = rx_data;
          end
        end
        // last byte closes the frame
        if (frame_position_next == POS_LAST) begin
          frame_store_next[0] = staged_command[0];
          frame_store_next[1] = staged_command[1];
          for (int k = STATUS_FIRST; k <= STATUS_LAST; k++) begin
            published_frame_next[k] = frame_store_next[k];
          end
          done_next = 1'b1;
        end
      end
      ACT_START: begin
        if (trigger_armed) begin
          if (frame_store[0] != 8'd0) begin
            if (frame_position == POS_LAST) begin
              shift_byte_next = frame_store[0];
              sending_next    = 1'b1;
            end else if (frame_position == 8'd0) begin
              shift_byte_next = frame_store[1];
              sending_next    = 1'b1;
            end
          end
          trigger_armed_next = 1'b0;
        end
      end
      ACT_TICK: begin
        if (sending) begin
          if (bit_index <= 4'd7) begin
            line_state_next = output_inverted ? tx_bit : !tx_bit;
            bit_index_next  = bit_index + 4'd1;
          end else begin
            bit_index_next  = 4'd0;
            line_state_next = !output_inverted;
            sending_next    = 1'b0;
          end
        end
      end
      ACT_STAGE: begin
        staged_command_next[0] = s1_cmd_first;
        staged_command_next[1] = s1_cmd_second;
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_threshold   <= GAP_THRESHOLD_RESET;
      output_inverted <= OUTPUT_INVERT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_GAP_THRESHOLD: gap_threshold   <= cfg_data;
        CFG_OUTPUT_INVERT: output_inverted <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // controller state update
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= 8'd0;
      last_byte_time <= 32'd0;
      for (int k = 0; k < STORE_DEPTH; k++) begin
        frame_store[k] <= 8'd0;
      end
      staged_command[0] <= 8'd0;
      staged_command[1] <= 8'd0;
      for (int k = STATUS_FIRST; k <= STATUS_LAST; k++) begin
        published_frame[k] <= 8'd0;
      end
      trigger_armed <= 1'b0;
      shift_byte    <= 8'd0;
      bit_index     <= 4'd0;
      sending       <= 1'b0;
      line_state    <= !OUTPUT_INVERT_RESET;
    end else begin
      if (process) begin
        frame_position  <= frame_position_next;
        last_byte_time  <= last_byte_time_next;
        frame_store     <= frame_store_next;
        staged_command  <= staged_command_next;
        published_frame <= published_frame_next;
        trigger_armed   <= trigger_armed_next;
        shift_byte      <= shift_byte_next;
        bit_index       <= bit_index_next;
        sending         <= sending_next;
        line_state      <= line_state_next;
      end
      // polarity change moves an idle line at once
      if (cfg_write && cfg_index == CFG_OUTPUT_INVERT && !sending) begin
        line_state <= !cfg_data[0];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
    if (process) begin
      line_level  <= line_state_next;
      tx_busy     <= sending_next;
      start_armed <= trigger_armed_next;
      frame_done  <= done_next;
      status_b2   <= published_frame_next[2];
      status_b3   <= published_frame_next[3];
      status_b4   <= published_frame_next[4];
      status_b5   <= published_frame_next[5];
      status_b6   <= published_frame_next[6];
      status_b7   <= published_frame_next[7];
    end
  end

  // a send ends only on a bit tick
  assert property (@(posedge clk) disable iff (rst)
    $fell(sending) |-> $past(process && s1_action == ACT_TICK))
    else $error("send ended without a bit tick");

  // bit counter stays within the eight data bits and the stop tick
  assert property (@(posedge clk) disable iff (rst)
    bit_index <= 4'd8)
    else $error("bit index out of range");

  // an idle transmitter has its bit counter cleared
  assert property (@(posedge clk) disable iff (rst)
    !sending |-> bit_index == 4'd0)
    else $error("bit index not cleared while idle");

  // a completed frame always leaves the start trigger armed
  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> start_armed)
    else $error("frame done without armed trigger");

  // a held input word is not overwritten
  assert property (@(posedge clk) disable iff (rst)
    in_stall |=> s1_valid && $stable(s1_now_ms) && $stable(s1_rx_byte))
    else $error("input register changed under stall");

endmodule
